// ----- sv/lsf_pkg.sv -----
// ----------------------------------------------------------------------------
// lsf_pkg: shared types and constants of the line substring filter
// Defaults for the sizes, register indexes, the line-end byte and the
// control groups passed between the top level and its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

  // default sizes
  localparam int LINE_MAX_DEF    = 64;
  localparam int PATTERN_MAX_DEF = 16;

  // fixed field widths
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;
  localparam int LEN_W     = 5;

  // line terminator
  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  // top level sequencer
  typedef enum logic {
    ST_RUN,
    ST_EMIT
  } state_t;

  // window cell control
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // line store control
  typedef struct packed {
    logic wr_en;
    logic start;
    logic start_ovf;
  } store_ctl_t;

endpackage

`default_nettype wire

// ----- sv/line_substring_filter_top.sv -----
// ----------------------------------------------------------------------------
// line_substring_filter_top: grep-style line filter
// Passes on whole lines of a byte stream that contain a configured pattern.
// ----------------------------------------------------------------------------
// Text bytes are taken one per cycle outside a readout; a newline byte or
// an item with tlast set ends the current line. The most recent PATTERN_MAX
// line bytes shift through a row of window cells, each comparing its byte
// with the aligned pattern byte, so any occurrence of the 1 to 16 byte
// pattern inside a line marks that line. A marked line is read back from
// the line buffer, one result item per cycle while the output is taken,
// with tlast on its final byte and tuser set there if the line was longer
// than LINE_MAX bytes (extra bytes are dropped but still matched). While a
// marked line is read out through the single read port of the line buffer,
// no input is taken. The user must write configuration only between lines,
// while no line is being emitted; the block itself does not enforce this.
// The window left by a byte is compared on the following item.
// ----------------------------------------------------------------------------
`default_nettype none

module line_substring_filter_top #(
  parameter int LINE_MAX    = lsf_pkg::LINE_MAX_DEF,
  parameter int PATTERN_MAX = lsf_pkg::PATTERN_MAX_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  // text input
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [lsf_pkg::BYTE_W-1:0]    s_tdata,   // text_byte
  input  wire                          s_tlast,   // end_of_buffer
  // matching lines
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [lsf_pkg::BYTE_W-1:0]   m_tdata,   // line_byte
  output logic                         m_tlast,   // last
  output logic                         m_tuser,   // truncated
  // configuration writes
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [lsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [lsf_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(LINE_MAX + 1);
  localparam int AW    = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam logic [CNT_W-1:0] LINE_FULL = CNT_W'(LINE_MAX);
  localparam logic [lsf_pkg::LEN_W-1:0] LEN_CAP = lsf_pkg::LEN_W'(PATTERN_MAX);

  // configuration registers
  logic [lsf_pkg::CFG_W-1:0] pattern_low;
  logic [lsf_pkg::CFG_W-1:0] pattern_high;
  logic [lsf_pkg::LEN_W-1:0] pattern_length;
  logic [2*lsf_pkg::CFG_W-1:0] pat_all;
  logic [lsf_pkg::LEN_W-1:0] act_len;

  // line state
  lsf_pkg::state_t state, state_next;
  logic [CNT_W-1:0] line_count;
  logic             overflowed;
  logic             line_matched;

  // handshake and control
  logic s_acc, is_end, byte_acc, end_acc;
  logic hit, line_hit, emit_go, emit_done, room;
  lsf_pkg::cell_ctl_t  cell_ctl;
  lsf_pkg::store_ctl_t store_ctl;

  // window row
  logic [lsf_pkg::BYTE_W-1:0] win_byte [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]     win_valid;
  logic [PATTERN_MAX-1:0]     cell_ok;

  // configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= lsf_pkg::LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsf_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        lsf_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        lsf_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[lsf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // length in use: zero counts as one, capped at the window size
  always_comb begin
    if (pattern_length == '0) begin
      act_len = lsf_pkg::LEN_W'(1);
    end else if (pattern_length > LEN_CAP) begin
      act_len = LEN_CAP;
    end else begin
      act_len = pattern_length;
    end
  end

  assign pat_all = {pattern_high, pattern_low};

  // input decode
  assign s_acc    = s_tvalid && s_tready;
  assign is_end   = s_tlast || (s_tdata == lsf_pkg::NEWLINE);
  assign byte_acc = s_acc && !is_end;
  assign end_acc  = s_acc && is_end;
  assign room     = (line_count < LINE_FULL);

  // match over the window as it stands; joined with earlier hits of the line
  assign hit      = &cell_ok;
  assign line_hit = line_matched || hit;
  assign emit_go  = end_acc && line_hit && (line_count != '0);

  assign cell_ctl.shift = byte_acc;
  assign cell_ctl.clear = end_acc;

  // row of window cells, newest byte in cell 0
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [lsf_pkg::LEN_W-1:0]  pat_idx;
    logic [lsf_pkg::BYTE_W-1:0] pat_byte;
    logic                       in_use;
    logic [lsf_pkg::BYTE_W-1:0] prev_byte;
    logic                       prev_valid;

    // cell k faces pattern byte (length - 1 - k)
    assign pat_idx  = act_len - lsf_pkg::LEN_W'(k) - lsf_pkg::LEN_W'(1);
    assign in_use   = (lsf_pkg::LEN_W'(k) < act_len);
    assign pat_byte = pat_all[{pat_idx[3:0], 3'b000} +: lsf_pkg::BYTE_W];

    if (k == 0) begin : g_head
      assign prev_byte  = s_tdata;
      assign prev_valid = 1'b1;
    end else begin : g_link
      assign prev_byte  = win_byte[k-1];
      assign prev_valid = win_valid[k-1];
    end

    lsf_window_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl),
      .in_byte   (prev_byte),
      .in_valid  (prev_valid),
      .pat_byte  (pat_byte),
      .in_use    (in_use),
      .out_byte  (win_byte[k]),
      .out_valid (win_valid[k]),
      .ok        (cell_ok[k])
    );
  end

  // line bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= '0;
      overflowed   <= 1'b0;
      line_matched <= 1'b0;
    end else if (end_acc) begin
      line_count   <= '0;
      overflowed   <= 1'b0;
      line_matched <= 1'b0;
    end else if (byte_acc) begin
      line_matched <= line_hit;
      if (room) begin
        line_count <= line_count + CNT_W'(1);
      end else begin
        overflowed <= 1'b1;
      end
    end
  end

  // line buffer and emit engine
  assign store_ctl.wr_en     = byte_acc && room;
  assign store_ctl.start     = emit_go;
  assign store_ctl.start_ovf = overflowed;

  lsf_line_store #(
    .LINE_MAX (LINE_MAX),
    .CNT_W    (CNT_W),
    .AW       (AW)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .ctl         (store_ctl),
    .wr_addr     (line_count[AW-1:0]),
    .wr_data     (s_tdata),
    .start_count (line_count),
    .done        (emit_done),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsf_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // input is held off while a line is read out
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      lsf_pkg::ST_RUN: begin
        s_tready = 1'b1;
        if (emit_go) begin
          state_next = lsf_pkg::ST_EMIT;
        end
      end
      lsf_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_next = lsf_pkg::ST_RUN;
        end
      end
      default: state_next = lsf_pkg::ST_RUN;
    endcase
  end

  // a matching line end always starts a readout
  a_emit_follows: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> (state == lsf_pkg::ST_EMIT))
    else $error("matching line end did not start readout");

  // no line byte is taken during a readout
  a_no_input_in_emit: assert property (@(posedge clk) disable iff (rst)
    (state == lsf_pkg::ST_EMIT) |-> !s_acc)
    else $error("input taken during readout");

  // the fill count never passes the buffer size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    line_count <= LINE_FULL)
    else $error("line count beyond buffer");

  // overflow only with a full buffer
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> (line_count == LINE_FULL))
    else $error("overflow flag with buffer not full");

  // a line end always leaves the line state cleared
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    end_acc |=> ((line_count == '0) && !line_matched && (win_valid == '0)))
    else $error("line state not cleared at line end");

endmodule

`default_nettype wire

// ----- sv/lsf_window_cell.sv -----
// ----------------------------------------------------------------------------
// lsf_window_cell: one byte position of the match window
// Holds one recent line byte and its fill bit, passes both to the next
// cell on every shift, and compares its byte against the pattern byte
// aligned to its position.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_window_cell (
  input  wire                       clk,
  input  wire                       rst,
  input  lsf_pkg::cell_ctl_t        ctl,
  input  wire [lsf_pkg::BYTE_W-1:0] in_byte,
  input  wire                       in_valid,
  input  wire [lsf_pkg::BYTE_W-1:0] pat_byte,
  input  wire                       in_use,
  output logic [lsf_pkg::BYTE_W-1:0] out_byte,
  output logic                      out_valid,
  output logic                      ok
);

  // fill bit: cleared at line end, follows the neighbor on a shift
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.clear) begin
      out_valid <= 1'b0;
    end else if (ctl.shift) begin
      out_valid <= in_valid;
    end
  end

  // byte held; only meaningful while the fill bit is set
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      out_byte <= in_byte;
    end
  end

  // positions past the pattern length always agree
  assign ok = !in_use || (out_valid && (out_byte == pat_byte));

endmodule

`default_nettype wire

// ----- sv/lsf_line_store.sv -----
// ----------------------------------------------------------------------------
// lsf_line_store: line buffer and emit engine
// Stores the bytes of the current line and, on request, reads them back
// in order into the output register, one item per cycle if not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_line_store #(
  parameter int LINE_MAX = lsf_pkg::LINE_MAX_DEF,
  parameter int CNT_W    = $clog2(LINE_MAX + 1),
  parameter int AW       = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
  input  wire                        clk,
  input  wire                        rst,
  input  lsf_pkg::store_ctl_t        ctl,
  input  wire [AW-1:0]               wr_addr,
  input  wire [lsf_pkg::BYTE_W-1:0]  wr_data,
  input  wire [CNT_W-1:0]            start_count,
  output logic                       done,
  output logic                       m_tvalid,
  input  wire                        m_tready,
  output logic [lsf_pkg::BYTE_W-1:0] m_tdata,  // line_byte
  output logic                       m_tlast,  // last
  output logic                       m_tuser   // truncated
);

  logic [lsf_pkg::BYTE_W-1:0] mem [LINE_MAX];
  logic [CNT_W-1:0]           rd_ptr;
  logic [CNT_W-1:0]           rd_ptr_next;
  logic [CNT_W-1:0]           emit_count;
  logic                       emit_ovf;
  logic                       emitting;
  logic                       issue;
  logic                       last_item;

  // line write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read one byte whenever the output register is free or being taken
  assign issue       = emitting && (!m_tvalid || m_tready);
  assign rd_ptr_next = rd_ptr + CNT_W'(1);
  assign last_item   = (rd_ptr_next == emit_count);
  assign done        = issue && last_item;

  // emit pointer and run control
  always_ff @(posedge clk) begin
    if (rst) begin
      emitting <= 1'b0;
      rd_ptr   <= '0;
    end else if (ctl.start) begin
      emitting <= 1'b1;
      rd_ptr   <= '0;
    end else if (issue) begin
      rd_ptr <= rd_ptr_next;
      if (last_item) begin
        emitting <= 1'b0;
      end
    end
  end

  // length and overflow flag of the line being emitted
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      emit_count <= start_count;
      emit_ovf   <= ctl.start_ovf;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (issue) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // registered read into the output register
  always_ff @(posedge clk) begin
    if (issue) begin
      m_tdata <= mem[rd_ptr[AW-1:0]];
      m_tlast <= last_item;
      m_tuser <= last_item && emit_ovf;
    end
  end

endmodule

`default_nettype wire
